FILE: design/lfsc_pkg.sv
`default_nettype none
package lfsc_pkg;

	localparam int MAX_DEPTH  = 32;
	localparam int MAX_LENGTH = 1024;

	localparam int CNT_W   = 11;
	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam int LEN_W   = $clog2(MAX_LENGTH + 2);
	localparam int LEVELS  = MAX_DEPTH + 1;

	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_AND   = 8'h26;
	localparam logic [7:0] CH_OR    = 8'h7c;
	localparam logic [7:0] CH_NOT   = 8'h21;
	localparam logic [7:0] CH_IMPL  = 8'h3e;
	localparam logic [7:0] CH_EQU   = 8'h7e;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	typedef struct packed {
		logic [CNT_W-1:0] brk;
		logic [CNT_W-1:0] opr;
		logic [CNT_W-1:0] opd;
	} cnt_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic inc_opd;
		logic inc_opr;
		logic clear;
	} cmd_t;

	function automatic logic level_ok(input cnt_t c);
		logic [CNT_W:0] two_opr;
		logic [CNT_W:0] opr_p1;
		two_opr = {c.opr, 1'b0};
		opr_p1  = {1'b0, c.opr} + {{CNT_W{1'b0}}, 1'b1};
		return ({1'b0, c.brk} == two_opr) && ({1'b0, c.opd} <= opr_p1);
	endfunction

endpackage
`default_nettype wire

FILE: design/lfsc_cell.sv
`default_nettype none
module lfsc_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          is_top,
	input  lfsc_pkg::cmd_t     cmd,
	input  lfsc_pkg::cnt_t     up_cnt,
	input  lfsc_pkg::cnt_t     dn_cnt,
	output lfsc_pkg::cnt_t     cnt,
	output lfsc_pkg::cnt_t     nxt
);
	import lfsc_pkg::*;

	cnt_t cnt_q;

	assign cnt = cnt_q;

	always_comb begin
		nxt = cnt_q;
		if (cmd.push) begin
			if (is_top) begin
				nxt.brk = CNT_W'(1);
				nxt.opr = '0;
				nxt.opd = '0;
			end else begin
				nxt = up_cnt;
			end
		end else if (cmd.pop) begin
			if (is_top) begin
				nxt.brk = dn_cnt.brk + cnt_q.brk + CNT_W'(1);
				nxt.opr = dn_cnt.opr + cnt_q.opr;
				nxt.opd = dn_cnt.opd + cnt_q.opd;
			end else begin
				nxt = dn_cnt;
			end
		end else if (is_top) begin
			if (cmd.inc_opd)
				nxt.opd = cnt_q.opd + CNT_W'(1);
			if (cmd.inc_opr)
				nxt.opr = cnt_q.opr + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: design/logic_formula_syntax_checker.sv
// result word: valid in the cycle after the last character word is accepted
// throughput: one character word per cycle while no result word waits untaken, no gaps between formulas
// the bracket stack is a row of cells shifting by one level per push or pop
// reset: asynchronous, clears the stack, depth, length count and result_valid; formula_ok and overflowed are not reset
`default_nettype none
module logic_formula_syntax_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_valid,
	output logic            char_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic            formula_ok,
	output logic            overflowed
);
	import lfsc_pkg::*;

	cnt_t cnt   [LEVELS];
	cnt_t nxt   [LEVELS];
	cnt_t up_in [LEVELS];
	cnt_t dn_in [LEVELS];
	cmd_t cmd;

	logic [DEPTH_W-1:0] depth_q, depth_nxt;
	logic [LEN_W-1:0]   len_q, len_nxt;
	logic               need_q, failed_q, limit_q, prev_ok_q;
	logic               accept;
	logic               is_opd, is_open, is_close, is_not, is_bin;
	logic               too_long, too_deep, fail_now, failed_nxt, limit_nxt, need_nxt;
	logic               ok_nxt;
	cnt_t               close_cnt;

	assign char_ready = !result_valid || result_ready;
	assign accept     = char_valid && char_ready;

	genvar k;
	generate
		for (k = 0; k < LEVELS; k++) begin : g_cell
			if (k == 0) begin : g_first
				assign up_in[k] = '0;
			end else begin : g_mid
				assign up_in[k] = cnt[k-1];
			end
			if (k == LEVELS - 1) begin : g_last
				assign dn_in[k] = '0;
			end else begin : g_more
				assign dn_in[k] = cnt[k+1];
			end
			lfsc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.is_top (k == 0),
				.cmd    (cmd),
				.up_cnt (up_in[k]),
				.dn_cnt (dn_in[k]),
				.cnt    (cnt[k]),
				.nxt    (nxt[k])
			);
		end
	endgenerate

	always_comb begin
		is_opd   = ((char_code >= CH_A) && (char_code <= CH_Z)) ||
		           (char_code == CH_ZERO) || (char_code == CH_ONE);
		is_open  = (char_code == CH_OPEN);
		is_close = (char_code == CH_CLOSE);
		is_not   = (char_code == CH_NOT);
		is_bin   = (char_code == CH_AND) || (char_code == CH_OR) ||
		           (char_code == CH_IMPL) || (char_code == CH_EQU);

		len_nxt  = (len_q <= LEN_W'(MAX_LENGTH)) ? len_q + LEN_W'(1) : len_q;
		too_long = (len_nxt > LEN_W'(MAX_LENGTH));
		too_deep = is_open && (depth_q >= DEPTH_W'(MAX_DEPTH));

		close_cnt     = cnt[0];
		close_cnt.brk = cnt[0].brk + CNT_W'(1);

		fail_now = too_long || too_deep ||
		           (need_q && !(is_opd || is_open)) ||
		           (is_close && (depth_q == '0)) ||
		           (is_close && (depth_q != '0) && !level_ok(close_cnt)) ||
		           (is_bin && !prev_ok_q) ||
		           !(is_opd || is_open || is_close || is_not || is_bin);

		failed_nxt = failed_q || fail_now;
		limit_nxt  = limit_q || too_long || too_deep;
		need_nxt   = is_not || is_bin;

		depth_nxt = depth_q;
		if (is_open && !too_deep)
			depth_nxt = depth_q + DEPTH_W'(1);
		else if (is_close && (depth_q != '0))
			depth_nxt = depth_q - DEPTH_W'(1);

		cmd.push    = accept && is_open && !too_deep;
		cmd.pop     = accept && is_close && (depth_q != '0);
		cmd.inc_opd = accept && is_opd;
		cmd.inc_opr = accept && (is_not || is_bin);
		cmd.clear   = accept && last_char;

		ok_nxt = !failed_nxt && !need_nxt && (depth_nxt == '0) && level_ok(nxt[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			len_q     <= '0;
			need_q    <= 1'b0;
			failed_q  <= 1'b0;
			limit_q   <= 1'b0;
			prev_ok_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				depth_q   <= '0;
				len_q     <= '0;
				need_q    <= 1'b0;
				failed_q  <= 1'b0;
				limit_q   <= 1'b0;
				prev_ok_q <= 1'b0;
			end else begin
				depth_q   <= depth_nxt;
				len_q     <= len_nxt;
				need_q    <= need_nxt;
				failed_q  <= failed_nxt;
				limit_q   <= limit_nxt;
				prev_ok_q <= is_opd || is_close;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (accept && last_char) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_char) begin
			formula_ok <= ok_nxt;
			overflowed <= limit_nxt;
		end
	end

endmodule
`default_nettype wire
